[rtl/i2d_pkg.sv]
// Shared types and constants for the integer to decimal ASCII converter.
package i2d_pkg;

   localparam int ValueWidth = 64;
   localparam int CountWidth = 5;
   localparam int DigitWidth = 4;
   localparam int CharWidth  = 8;

   localparam logic [CharWidth-1:0] AsciiZero  = 8'h30;
   localparam logic [CharWidth-1:0] AsciiMinus = 8'h2D;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  is_signed;
   } req_type;

   typedef struct packed {
      logic [CharWidth-1:0]  character;
      logic                  last;
      logic [CountWidth-1:0] length;
   } rsp_type;

   // Commands from the sequencer to the conversion unit
   typedef struct packed {
      logic start;
      logic pop;
   } cv_ctrl_type;

   // Status from the conversion unit to the sequencer
   typedef struct packed {
      logic                  done;
      logic [CountWidth-1:0] count;
      logic [DigitWidth-1:0] digit;
   } cv_stat_type;

   typedef enum logic [1:0] {
      CV_IDLE,
      CV_SHIFT,
      CV_TRIM,
      CV_DONE
   } cv_phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } top_state_type;

endpackage

[rtl/integer_to_decimal_ascii.sv]
// Top level: 64-bit integer to decimal ASCII character stream.
//
//  channel  direction  payload                       handshake
//  req      in         value[63:0], is_signed        req_valid / req_stall
//  rsp      out        character[7:0], last, length  rsp_valid / rsp_stall
//
// An item goes through bit-serial shift-add-3 conversion, then trims leading zero digits
// (up to MAX_DIGITS-1), then emits one character per output transfer (up to 20), sign
// first; a new request is taken only once the last character is in the output register.
// The conversion runs as a 64-step shift loop in i2d_convert.
// Reset is synchronous and clears the control state only.
// req_stall is high from a transfer until its last character sits in the output
// register; rsp_stall holds the output register and pauses character emission.
module integer_to_decimal_ascii #(
   parameter int MAX_DIGITS = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i2d_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i2d_pkg::rsp_type rsp_data
);
   import i2d_pkg::*;

   top_state_type         state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [CountWidth-1:0] total_ff, total_in;
   logic [CountWidth-1:0] remain_ff, remain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   cv_ctrl_type           cv_ctrl;
   cv_stat_type           cv_stat;
   logic [ValueWidth-1:0] magnitude;
   logic                  req_neg;
   logic                  req_xfer;
   logic                  out_free;

   i2d_convert #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_convert (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cv_ctrl),
      .magnitude (magnitude),
      .stat      (cv_stat)
   );

   // Form the unsigned magnitude of the incoming value
   assign req_neg   = req_data.is_signed & req_data.value[ValueWidth-1];
   assign magnitude = req_neg ? (~req_data.value + 1'b1) : req_data.value;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sequence conversion and character emission
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      total_in     = total_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cv_ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cv_ctrl.start = 1'b1;
               neg_in        = req_neg;
               state_in      = ST_CONV;
            end
         end
         ST_CONV: begin
            if (cv_stat.done) begin
               total_in  = cv_stat.count + CountWidth'(neg_ff);
               remain_in = cv_stat.count + CountWidth'(neg_ff);
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               // Load the sign first, then one digit per transfer
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_data_in.character = AsciiMinus;
                  neg_in                = 1'b0;
               end else begin
                  rsp_data_in.character = AsciiZero | CharWidth'(cv_stat.digit);
                  cv_ctrl.pop           = 1'b1;
               end
               rsp_data_in.last   = (remain_ff == CountWidth'(1));
               rsp_data_in.length = (remain_ff == CountWidth'(1)) ? total_ff : '0;
               remain_in          = remain_ff - 1'b1;
               if (remain_ff == CountWidth'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      total_ff    <= total_in;
      remain_ff   <= remain_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A transfer starts the conversion unit afresh
   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_CONV) && !cv_stat.done)
      else $error("conversion did not restart after input transfer");

   // Emission always has characters left to send
   a_emit_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (remain_ff != '0))
      else $error("emit state with no characters left");

   // The final character carries a nonzero length and nothing else does
   a_length_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.last == (rsp_data_ff.length != '0)))
      else $error("length does not match last flag");

   // The digit count handed to emission is at least one and within the digit limit
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && cv_stat.done) |->
         (cv_stat.count != '0) && (cv_stat.count <= CountWidth'(MAX_DIGITS)))
      else $error("digit count out of range");

endmodule

[rtl/i2d_convert.sv]
// Bit-serial shift-add-3 binary to BCD unit with leading zero trim and digit shift-out.
module i2d_convert #(
   parameter int MAX_DIGITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  i2d_pkg::cv_ctrl_type              ctrl,
   input  logic [i2d_pkg::ValueWidth-1:0]    magnitude,
   output i2d_pkg::cv_stat_type              stat
);
   import i2d_pkg::*;

   localparam int BcdWidth      = MAX_DIGITS * DigitWidth;
   localparam int BitCountWidth = $clog2(ValueWidth);

   cv_phase_type             phase_ff, phase_in;
   logic [ValueWidth-1:0]    mag_ff, mag_in;
   logic [BcdWidth-1:0]      bcd_ff, bcd_in;
   logic [BitCountWidth-1:0] bit_cnt_ff, bit_cnt_in;
   logic [CountWidth-1:0]    ndig_ff, ndig_in;
   logic                     ovf_ff, ovf_in;

   logic [BcdWidth-1:0]   bcd_adj;
   logic [DigitWidth-1:0] top_digit;

   // Correct every digit of five or more before the doubling shift
   always_comb begin
      bcd_adj = bcd_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*DigitWidth +: DigitWidth] >= 4'd5) begin
            bcd_adj[i*DigitWidth +: DigitWidth] = bcd_ff[i*DigitWidth +: DigitWidth] + 4'd3;
         end
      end
   end

   assign top_digit = bcd_ff[BcdWidth-1 -: DigitWidth];

   // Sequence shift, trim and shift-out phases
   always_comb begin
      phase_in   = phase_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      ndig_in    = ndig_ff;
      ovf_in     = ovf_ff;
      if (ctrl.start) begin
         phase_in   = CV_SHIFT;
         mag_in     = magnitude;
         bcd_in     = '0;
         bit_cnt_in = '0;
         ndig_in    = CountWidth'(MAX_DIGITS);
         ovf_in     = 1'b0;
      end else begin
         case (phase_ff)
            CV_SHIFT: begin
               // Shift one magnitude bit into the digits; a carry off the top marks overflow
               bcd_in     = {bcd_adj[BcdWidth-2:0], mag_ff[ValueWidth-1]};
               ovf_in     = ovf_ff | bcd_adj[BcdWidth-1];
               mag_in     = {mag_ff[ValueWidth-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == BitCountWidth'(ValueWidth - 1)) begin
                  phase_in = CV_TRIM;
               end
            end
            CV_TRIM: begin
               // Drop one leading zero digit per cycle, keep at least one digit
               if (ovf_ff || ndig_ff == CountWidth'(1) || top_digit != '0) begin
                  phase_in = CV_DONE;
               end else begin
                  bcd_in  = {bcd_ff[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
                  ndig_in = ndig_ff - 1'b1;
               end
            end
            CV_DONE: begin
               // Advance to the next digit on request
               if (ctrl.pop) begin
                  bcd_in = {bcd_ff[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
               end
            end
            default: begin
               phase_in = CV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= CV_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      ndig_ff    <= ndig_in;
      ovf_ff     <= ovf_in;
   end

   assign stat.done  = (phase_ff == CV_DONE);
   assign stat.count = ndig_ff;
   assign stat.digit = top_digit;

endmodule
